/* rtl/bech32_pkg.sv */
// ----------------------------------------------------------------------------
// Bech32 encoder package
// Shared constants, types and the checksum step functions of the Bech32
// encoder.
// ----------------------------------------------------------------------------
package bech32_pkg;

  localparam int unsigned CharW  = 7;
  localparam int unsigned CheckW = 30;
  localparam int unsigned SymW   = 5;
  localparam int unsigned CntW   = 3;

  localparam logic [CheckW-1:0] CHECK_INIT = 30'd1;
  localparam logic [CharW-1:0]  SEP_CHAR   = 7'h31;
  localparam logic [CntW-1:0]   CK_LAST    = 3'd5;
  localparam logic [CntW-1:0]   SYM_SECOND = 3'd1;

  localparam logic [1:0] CFG_PREFIX0 = 2'd0;
  localparam logic [1:0] CFG_PREFIX1 = 2'd1;
  localparam logic [1:0] CFG_PREFIX2 = 2'd2;

  localparam logic [CharW-1:0] PREFIX0_RST = 7'd97;
  localparam logic [CharW-1:0] PREFIX1_RST = 7'd103;
  localparam logic [CharW-1:0] PREFIX2_RST = 7'd101;

  localparam logic [CheckW-1:0] GEN_POLY [5] = '{
    30'h3b6a57b2, 30'h26508e6d, 30'h1ea119fa, 30'h3d4233dd, 30'h2a1462b3
  };

  // Character set "qpzry9x8gf2tvdw0s3jn54khce6mua7l", indexed by symbol.
  localparam logic [CharW-1:0] ALPHABET [32] = '{
    7'h71, 7'h70, 7'h7a, 7'h72, 7'h79, 7'h39, 7'h78, 7'h38,
    7'h67, 7'h66, 7'h32, 7'h74, 7'h76, 7'h64, 7'h77, 7'h30,
    7'h73, 7'h33, 7'h6a, 7'h6e, 7'h35, 7'h34, 7'h6b, 7'h68,
    7'h63, 7'h65, 7'h36, 7'h6d, 7'h75, 7'h61, 7'h37, 7'h6c
  };

  typedef enum logic [2:0] {
    PH_PRE0,
    PH_PRE1,
    PH_PRE2,
    PH_SEP,
    PH_SYM,
    PH_PAD,
    PH_CK
  } phase_e;

  // One polymod step: shift in a 5-bit symbol and reduce by the generator.
  function automatic logic [CheckW-1:0] fold(input logic [CheckW-1:0] chk,
                                             input logic [SymW-1:0]   sym);
    logic [SymW-1:0]   top;
    logic [CheckW-1:0] res;
    top = chk[29:25];
    res = {chk[24:0], sym};
    for (int j = 0; j < 5; j++) begin
      if (top[j]) begin
        res = res ^ GEN_POLY[j];
      end
    end
    return res;
  endfunction

  // Six zero symbols folded in, as at the end of every string.
  function automatic logic [CheckW-1:0] fold_zeros(input logic [CheckW-1:0] chk);
    logic [CheckW-1:0] res;
    res = chk;
    for (int k = 0; k < 6; k++) begin
      res = fold(res, 5'd0);
    end
    return res;
  endfunction

endpackage

/* rtl/bech32_checksum_encoder.sv */
// ----------------------------------------------------------------------------
// Bech32 checksum encoder
// Turns a stream of payload bytes into a Bech32 text string, one ASCII
// character per output item, with prefix, separator and six checksum
// characters.
// ----------------------------------------------------------------------------
// The block emits exactly one character per clock cycle while a byte is held
// and the output side is ready, so its rate is set by the output channel and
// the byte supply. A payload byte yields one or two symbols; the first byte of
// a message also yields the three prefix characters and the separator, and the
// last byte yields a padding symbol when bits are left over plus the six
// checksum characters. Averaged over a long message this comes to 1.6
// characters per byte. An input register holds the byte being encoded and an
// output register holds the character on offer, so the next byte is taken in
// the same cycle in which the final character of the current one is produced.
module bech32_checksum_encoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,   // last_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [6:0] text_char, [7] zero
  output logic       m_axis_tlast_o,   // end_of_string
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_idx_i,
  input  logic [6:0] cfg_data_i
);

  logic [bech32_pkg::CharW-1:0] prefix0_q, prefix1_q, prefix2_q;

  logic       item_valid_q, item_valid_d;
  logic [7:0] byte_q;
  logic       last_q;

  bech32_pkg::phase_e             phase_q, phase_d;
  logic [bech32_pkg::CntW-1:0]    cnt_q, cnt_d;
  logic [bech32_pkg::CheckW-1:0]  check_q, check_d;
  logic [3:0]                     lo_bits_q, lo_bits_d;
  logic [2:0]                     lo_cnt_q, lo_cnt_d;

  logic                           m_valid_q, m_valid_d;
  logic [bech32_pkg::CharW-1:0]   m_char_q, char_d;
  logic                           m_last_q, eos_d;

  logic out_free, step, item_done, in_accept;

  logic [11:0]                    acc;
  logic                           two_sym;
  logic [2:0]                     sym_shift;
  logic [bech32_pkg::SymW-1:0]    data_sym;
  logic [2:0]                     new_cnt;
  logic [4:0]                     new_mask;
  logic [bech32_pkg::SymW-1:0]    pad_sym;
  logic [bech32_pkg::CheckW-1:0]  pm;
  logic [11:0]                    acc_shifted;
  logic [4:0]                     pad_wide;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign step            = item_valid_q && out_free;
  assign s_axis_tready_o = !item_valid_q || (step && item_done);
  assign in_accept       = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_char_q};
  assign m_axis_tlast_o  = m_last_q;

  // Regrouping of the held byte with the bits left from the previous one.
  assign acc         = {lo_bits_q, byte_q};
  assign two_sym     = (lo_cnt_q >= 3'd2);
  assign sym_shift   = (cnt_q == bech32_pkg::SYM_SECOND) ? (lo_cnt_q - 3'd2)
                                                         : (lo_cnt_q + 3'd3);
  assign acc_shifted = acc >> sym_shift;
  assign data_sym    = acc_shifted[4:0];
  assign new_cnt     = two_sym ? (lo_cnt_q - 3'd2) : (lo_cnt_q + 3'd3);
  assign new_mask    = (5'd1 << new_cnt) - 5'd1;
  assign pad_wide    = {1'b0, lo_bits_q} << (3'd5 - lo_cnt_q);
  assign pad_sym     = pad_wide;
  assign pm          = bech32_pkg::fold_zeros(check_q) ^ bech32_pkg::CHECK_INIT;

  // Next phase of the character sequencer.
  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    item_done = 1'b0;
    if (step) begin
      case (phase_q)
        bech32_pkg::PH_PRE0: phase_d = bech32_pkg::PH_PRE1;
        bech32_pkg::PH_PRE1: phase_d = bech32_pkg::PH_PRE2;
        bech32_pkg::PH_PRE2: phase_d = bech32_pkg::PH_SEP;
        bech32_pkg::PH_SEP: begin
          phase_d = bech32_pkg::PH_SYM;
          cnt_d   = '0;
        end
        bech32_pkg::PH_SYM: begin
          if (!two_sym || cnt_q == bech32_pkg::SYM_SECOND) begin
            cnt_d = '0;
            if (!last_q) begin
              item_done = 1'b1;
            end else if (new_cnt != 3'd0) begin
              phase_d = bech32_pkg::PH_PAD;
            end else begin
              phase_d = bech32_pkg::PH_CK;
            end
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        bech32_pkg::PH_PAD: begin
          phase_d = bech32_pkg::PH_CK;
          cnt_d   = '0;
        end
        bech32_pkg::PH_CK: begin
          if (cnt_q == bech32_pkg::CK_LAST) begin
            item_done = 1'b1;
            phase_d   = bech32_pkg::PH_PRE0;
            cnt_d     = '0;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
        default: begin
          phase_d = bech32_pkg::PH_PRE0;
          cnt_d   = '0;
        end
      endcase
    end
  end

  // Character, checksum and leftover update for the current step.
  always_comb begin
    char_d    = bech32_pkg::SEP_CHAR;
    eos_d     = 1'b0;
    check_d   = check_q;
    lo_bits_d = lo_bits_q;
    lo_cnt_d  = lo_cnt_q;
    case (phase_q)
      bech32_pkg::PH_PRE0: begin
        char_d  = prefix0_q;
        check_d = bech32_pkg::fold(bech32_pkg::fold(bech32_pkg::CHECK_INIT,
                                                    {3'd0, prefix0_q[6:5]}),
                                   {3'd0, prefix1_q[6:5]});
      end
      bech32_pkg::PH_PRE1: begin
        char_d  = prefix1_q;
        check_d = bech32_pkg::fold(bech32_pkg::fold(check_q, {3'd0, prefix2_q[6:5]}),
                                   5'd0);
      end
      bech32_pkg::PH_PRE2: begin
        char_d  = prefix2_q;
        check_d = bech32_pkg::fold(bech32_pkg::fold(check_q, prefix0_q[4:0]),
                                   prefix1_q[4:0]);
      end
      bech32_pkg::PH_SEP: begin
        char_d  = bech32_pkg::SEP_CHAR;
        check_d = bech32_pkg::fold(check_q, prefix2_q[4:0]);
      end
      bech32_pkg::PH_SYM: begin
        char_d  = bech32_pkg::ALPHABET[data_sym];
        check_d = bech32_pkg::fold(check_q, data_sym);
        if (!two_sym || cnt_q == bech32_pkg::SYM_SECOND) begin
          lo_cnt_d  = new_cnt;
          lo_bits_d = byte_q[3:0] & new_mask[3:0];
        end
      end
      bech32_pkg::PH_PAD: begin
        char_d  = bech32_pkg::ALPHABET[pad_sym];
        check_d = bech32_pkg::fold(check_q, pad_sym);
      end
      bech32_pkg::PH_CK: begin
        if (cnt_q == 3'd0) begin
          char_d  = bech32_pkg::ALPHABET[pm[29:25]];
          check_d = {pm[24:0], 5'd0};
        end else begin
          char_d  = bech32_pkg::ALPHABET[check_q[29:25]];
          check_d = {check_q[24:0], 5'd0};
        end
        if (cnt_q == bech32_pkg::CK_LAST) begin
          eos_d     = 1'b1;
          check_d   = bech32_pkg::CHECK_INIT;
          lo_bits_d = '0;
          lo_cnt_d  = '0;
        end
      end
      default: begin
        char_d = bech32_pkg::SEP_CHAR;
      end
    endcase
  end

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_accept) begin
      item_valid_d = 1'b1;
    end else if (step && item_done) begin
      item_valid_d = 1'b0;
    end
    m_valid_d = m_valid_q;
    if (step) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix0_q    <= bech32_pkg::PREFIX0_RST;
      prefix1_q    <= bech32_pkg::PREFIX1_RST;
      prefix2_q    <= bech32_pkg::PREFIX2_RST;
      item_valid_q <= 1'b0;
      m_valid_q    <= 1'b0;
      phase_q      <= bech32_pkg::PH_PRE0;
      cnt_q        <= '0;
      check_q      <= bech32_pkg::CHECK_INIT;
      lo_bits_q    <= '0;
      lo_cnt_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bech32_pkg::CFG_PREFIX0: prefix0_q <= cfg_data_i;
          bech32_pkg::CFG_PREFIX1: prefix1_q <= cfg_data_i;
          bech32_pkg::CFG_PREFIX2: prefix2_q <= cfg_data_i;
          default: ;
        endcase
      end
      item_valid_q <= item_valid_d;
      m_valid_q    <= m_valid_d;
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      if (step) begin
        check_q   <= check_d;
        lo_bits_q <= lo_bits_d;
        lo_cnt_q  <= lo_cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      byte_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    if (step) begin
      m_char_q <= char_d;
      m_last_q <= eos_d;
    end
  end

`ifndef SYNTHESIS
  a_lo_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lo_cnt_q <= 3'd4)
    else $error("leftover bit count out of range");

  a_eos_on_last_ck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && phase_q == bech32_pkg::PH_CK && cnt_q == bech32_pkg::CK_LAST)
    |=> (m_axis_tvalid_o && m_axis_tlast_o && check_q == bech32_pkg::CHECK_INIT
         && phase_q == bech32_pkg::PH_PRE0))
    else $error("string end not marked or state not restored");

  a_no_tlast_elsewhere: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !(phase_q == bech32_pkg::PH_CK && cnt_q == bech32_pkg::CK_LAST))
    |=> !m_axis_tlast_o)
    else $error("end of string marked on a non-final character");
`endif

endmodule

/* sim/bech32_text_checker.sv */
// ----------------------------------------------------------------------------
// Bech32 text checker
// Watches the byte and character streams of the Bech32 encoder and its
// register writes. It keeps its own model of the checksum state, works out
// the characters that each accepted byte must produce, and compares every
// accepted character with the oldest one still expected.
// ----------------------------------------------------------------------------
module bech32_text_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,
  input  logic        in_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [7:0]  out_data_i,
  input  logic        out_last_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [6:0]  cfg_data_i,
  output int unsigned fail_cnt_o,
  output int unsigned pend_cnt_o,
  output int unsigned byte_cnt_o,
  output int unsigned char_cnt_o,
  output int unsigned str_cnt_o
);

  typedef struct packed {
    logic [6:0] ch;
    logic       eos;
  } text_item_t;

  localparam logic [255:0] CHARSET   = "qpzry9x8gf2tvdw0s3jn54khce6mua7l";
  localparam logic [6:0]   DELIMITER = 7'h31;
  localparam logic [4:0][29:0] GEN = {
    30'h2a1462b3, 30'h3d4233dd, 30'h1ea119fa, 30'h26508e6d, 30'h3b6a57b2
  };

  text_item_t  expected_chars_q [$];
  logic [6:0]  hrp [3];
  logic [29:0] chk;
  logic [3:0]  rem_bits;
  int unsigned rem_cnt;
  logic        msg_open;
  int unsigned fails, n_bytes, n_chars, n_strs;

  function automatic logic [29:0] poly_mix(input logic [29:0] c, input logic [4:0] s);
    logic [4:0]  hi;
    logic [29:0] r;
    hi = c[29:25];
    r  = {c[24:0], s};
    for (int j = 0; j < 5; j++) begin
      r = r ^ ({30{hi[j]}} & GEN[j]);
    end
    return r;
  endfunction

  function automatic logic [6:0] sym_char(input logic [4:0] s);
    logic [7:0] c;
    c = CHARSET[8*(31-s) +: 8];
    return c[6:0];
  endfunction

  // Appends the characters that one payload byte produces and advances the
  // running checksum.
  task automatic predict_string_chars(input logic [7:0] b, input logic l);
    logic [11:0] acc;
    logic [4:0]  s;
    logic [29:0] pm;
    int          nb;
    if (!msg_open) begin
      chk      = 30'd1;
      rem_bits = '0;
      rem_cnt  = 0;
      for (int i = 0; i < 3; i++) begin
        expected_chars_q.push_back('{ch: hrp[i], eos: 1'b0});
      end
      expected_chars_q.push_back('{ch: DELIMITER, eos: 1'b0});
      for (int i = 0; i < 3; i++) begin
        chk = poly_mix(chk, {3'b000, hrp[i][6:5]});
      end
      chk = poly_mix(chk, 5'd0);
      for (int i = 0; i < 3; i++) begin
        chk = poly_mix(chk, hrp[i][4:0]);
      end
      msg_open = 1'b1;
    end
    acc = {rem_bits, b};
    nb  = rem_cnt + 8;
    while (nb >= 5) begin
      nb = nb - 5;
      s  = acc[nb +: 5];
      expected_chars_q.push_back('{ch: sym_char(s), eos: 1'b0});
      chk = poly_mix(chk, s);
    end
    rem_cnt  = nb;
    rem_bits = 4'(acc & ((12'd1 << nb) - 12'd1));
    if (l) begin
      if (rem_cnt != 0) begin
        s = 5'({1'b0, rem_bits} << (5 - rem_cnt));
        expected_chars_q.push_back('{ch: sym_char(s), eos: 1'b0});
        chk = poly_mix(chk, s);
      end
      for (int i = 0; i < 6; i++) begin
        chk = poly_mix(chk, 5'd0);
      end
      pm = chk ^ 30'd1;
      for (int i = 0; i < 6; i++) begin
        s = pm[5*(5-i) +: 5];
        expected_chars_q.push_back('{ch: sym_char(s), eos: (i == 5)});
      end
      chk      = 30'd1;
      rem_bits = '0;
      rem_cnt  = 0;
      msg_open = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    text_item_t want;
    if (!rst_ni) begin
      hrp[0]   = bech32_pkg::PREFIX0_RST;
      hrp[1]   = bech32_pkg::PREFIX1_RST;
      hrp[2]   = bech32_pkg::PREFIX2_RST;
      chk      = 30'd1;
      rem_bits = '0;
      rem_cnt  = 0;
      msg_open = 1'b0;
      fails    = 0;
      n_bytes  = 0;
      n_chars  = 0;
      n_strs   = 0;
      expected_chars_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          bech32_pkg::CFG_PREFIX0: hrp[0] = cfg_data_i;
          bech32_pkg::CFG_PREFIX1: hrp[1] = cfg_data_i;
          bech32_pkg::CFG_PREFIX2: hrp[2] = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        n_chars++;
        if (out_last_i === 1'b1) begin
          n_strs++;
        end
        if (expected_chars_q.size() == 0) begin
          $error("unexpected character %h with none expected", out_data_i);
          fails++;
        end else begin
          want = expected_chars_q.pop_front();
          if (out_data_i[6:0] !== want.ch) begin
            $error("text_char mismatch: expected %h, actual %h", want.ch, out_data_i[6:0]);
            fails++;
          end
          if (out_last_i !== want.eos) begin
            $error("end_of_string mismatch: expected %b, actual %b", want.eos, out_last_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        n_bytes++;
        predict_string_chars(in_data_i, in_last_i);
      end
    end
    fail_cnt_o <= fails;
    pend_cnt_o <= expected_chars_q.size();
    byte_cnt_o <= n_bytes;
    char_cnt_o <= n_chars;
    str_cnt_o  <= n_strs;
  end

endmodule

/* sim/tb_bech32_checksum_encoder.sv */
// ----------------------------------------------------------------------------
// Bech32 checksum encoder testbench
// Feeds directed and random payload messages to the encoder under several
// prefix settings, with random gaps on the byte side and random stalls on
// the character side. A checker module predicts and compares every
// character; this module makes the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_bech32_checksum_encoder;

  localparam int unsigned LIMIT  = 1000000;
  localparam int unsigned SETTLE = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [6:0]  cfg_data;
  logic        no_idle;
  int unsigned fail_cnt, pend_cnt, byte_cnt, char_cnt, str_cnt;
  int unsigned settings;
  int unsigned cyc;

  bech32_checksum_encoder DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  bech32_text_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_tvalid),
    .in_ready_i  (s_tready),
    .in_data_i   (s_tdata),
    .in_last_i   (s_tlast),
    .out_valid_i (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_i  (m_tdata),
    .out_last_i  (m_tlast),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pend_cnt_o  (pend_cnt),
    .byte_cnt_o  (byte_cnt),
    .char_cnt_o  (char_cnt),
    .str_cnt_o   (str_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 15);
    if (r < 8) begin
      return 0;
    end
    if (r < 15) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return 8'h00;
    end
    if (r == 1) begin
      return 8'hff;
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [6:0] rand_prefix_char();
    int r;
    r = $urandom_range(0, 11);
    case (r)
      0:       return 7'd0;
      1:       return 7'd127;
      2:       return 7'd33;
      3:       return 7'd126;
      default: return 7'($urandom_range(33, 126));
    endcase
  endfunction

  initial begin
    int hold;
    hold     = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold == 0 && !no_idle && $urandom_range(0, 3) == 0) begin
        hold = idle_len();
      end
      if (no_idle) begin
        hold = 0;
      end
      m_tready <= (hold == 0);
      if (hold > 0) begin
        hold--;
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic l);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Holds the sender off until every expected character has come out.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_prefix(input logic [6:0] c0, input logic [6:0] c1,
                              input logic [6:0] c2);
    cfg_we   <= 1'b1;
    cfg_idx  <= bech32_pkg::CFG_PREFIX0;
    cfg_data <= c0;
    @(posedge clk_i);
    cfg_idx  <= bech32_pkg::CFG_PREFIX1;
    cfg_data <= c1;
    @(posedge clk_i);
    cfg_idx  <= bech32_pkg::CFG_PREFIX2;
    cfg_data <= c2;
    @(posedge clk_i);
    cfg_we   <= 1'b0;
    settings++;
  endtask

  task automatic push_msg(input logic [7:0] m [$]);
    for (int i = 0; i < m.size(); i++) begin
      push_byte(m[i], i == m.size() - 1);
    end
  endtask

  initial begin
    cyc = 0;
    while (cyc < LIMIT) begin
      @(posedge clk_i);
      cyc++;
    end
    $error("run did not complete within %0d cycles", LIMIT);
    $display("tb_bech32_checksum_encoder failed");
    $finish;
  end

  initial begin
    int len, mid, sent;
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tlast  = 1'b0;
    cfg_we   = 1'b0;
    cfg_idx  = bech32_pkg::CFG_PREFIX0;
    cfg_data = '0;
    no_idle  = 1'b0;
    settings = 1;
    sent     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset prefix, single-byte message, a message that ends
    // with no leftover bits, a prefix change in the middle of a message, and
    // prefix characters at and beyond the printable range.
    push_msg('{8'h00});
    push_msg('{8'hff, 8'h00, 8'hff, 8'h00, 8'hff});
    push_byte(8'ha5, 1'b0);
    drain();
    write_prefix(7'd33, 7'd126, 7'h7a);
    push_byte(8'h5a, 1'b1);
    push_msg('{8'h80});
    drain();
    write_prefix(7'd0, 7'd127, 7'h55);
    push_msg('{8'h01, 8'hfe});
    no_idle = 1'b1;
    push_msg('{8'h12, 8'h34, 8'h56, 8'h78});
    no_idle = 1'b0;
    push_msg('{8'hde, 8'had, 8'hbe});
    drain();
    write_prefix(bech32_pkg::PREFIX0_RST, bech32_pkg::PREFIX1_RST,
                 bech32_pkg::PREFIX2_RST);

    while (sent < 350) begin
      len     = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      no_idle = ($urandom_range(0, 4) == 0);
      mid     = (len > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, len - 1) : 0;
      for (int k = 0; k < len; k++) begin
        if (mid != 0 && k == mid) begin
          drain();
          write_prefix(rand_prefix_char(), rand_prefix_char(), rand_prefix_char());
        end
        push_byte(rand_byte(), k == len - 1);
      end
      sent += len;
      if ($urandom_range(0, 5) == 0) begin
        drain();
        write_prefix(rand_prefix_char(), rand_prefix_char(), rand_prefix_char());
      end
    end
    no_idle = 1'b0;
    drain();

    $display("Encoded %0d payload bytes into %0d strings, %0d characters checked.",
             byte_cnt, str_cnt, char_cnt);
    $display("Used %0d prefix settings, with gaps and stalls on both streams.", settings);
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("tb_bech32_checksum_encoder passed");
    end else begin
      $display("tb_bech32_checksum_encoder failed");
    end
    $finish;
  end

endmodule
